// ----- rtl/core/assert_macros.svh -----
// Concurrent assertion macros shared by the I2C status handler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_HOLDS(label, clk, rst_n, prop, msg)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/core/i2cms_pkg.sv -----
// Types and constants of the I2C master status handler.
`timescale 1ns / 1ps

package i2cms_pkg;

  // Request kinds carried in tuser
  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_READ   = 2'd1,
    REQ_START  = 2'd2,
    REQ_STATUS = 2'd3
  } req_e;

  // Latched transaction outcome
  typedef enum logic [2:0] {
    DONE_BUSY        = 3'd0,
    DONE_ADDR_W_NACK = 3'd1,
    DONE_WRITE_OK    = 3'd2,
    DONE_DATA_NACK   = 3'd3,
    DONE_ARB_LOST    = 3'd4,
    DONE_ADDR_R_NACK = 3'd5,
    DONE_READ_OK     = 3'd6
  } done_e;

  // Controller status codes
  localparam logic [7:0] ST_BUS_ERROR   = 8'h00;
  localparam logic [7:0] ST_START       = 8'h08;
  localparam logic [7:0] ST_RESTART     = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK   = 8'h18;
  localparam logic [7:0] ST_SLA_W_NACK  = 8'h20;
  localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
  localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST    = 8'h38;
  localparam logic [7:0] ST_SLA_R_ACK   = 8'h40;
  localparam logic [7:0] ST_SLA_R_NACK  = 8'h48;
  localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
  localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_COUNT = 2'd2;

  localparam int unsigned SLAVE_W    = 7;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned S_TDATA_W  = 24;
  localparam int unsigned S_TUSER_W  = 2;
  localparam int unsigned M_TDATA_W  = 32;

  // Buffer access request toward the RAM
  typedef struct packed {
    logic en;
    logic we;
  } mem_ctl_t;

  // Decoded result of one item, minus the byte read from the buffer
  typedef struct packed {
    logic       tx_valid;
    logic       tx_from_mem;
    logic [7:0] tx_fixed;
    logic       set_start;
    logic       clear_start;
    logic       set_stop;
    logic       set_ack;
    logic       clear_ack;
    logic       clear_irq;
    logic       rd_from_mem;
    logic [2:0] done_code;
  } res_t;

endpackage

// ----- rtl/core/i2cms_buf_ram.sv -----
// Byte buffer: single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps

module i2cms_buf_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                clk_i,
  input  i2cms_pkg::mem_ctl_t ctl_i,
  input  logic [AW-1:0]       addr_i,
  input  logic [7:0]          wdata_i,
  output logic [7:0]          rdata_o
);
  import i2cms_pkg::*;

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      if (ctl_i.we) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/i2cms_seq.sv -----
// Status decoder with byte index, outcome and configuration registers.
`timescale 1ns / 1ps

module i2cms_seq #(
  parameter int unsigned BUFFER_DEPTH = 16,
  parameter int unsigned AW           = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 fire_i,
  input  i2cms_pkg::req_e                      req_i,
  input  logic [i2cms_pkg::POS_W-1:0]          pos_i,
  input  logic [7:0]                           data_i,
  input  logic [7:0]                           status_i,
  input  logic                                 cfg_we_i,
  input  logic [i2cms_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [i2cms_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output i2cms_pkg::mem_ctl_t                  mem_ctl_o,
  output logic [AW-1:0]                        mem_addr_o,
  output logic [7:0]                           mem_wdata_o,
  output i2cms_pkg::res_t                      res_o
);
  import i2cms_pkg::*;

  localparam int unsigned IW = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned CW = (IW > COUNT_W) ? IW : COUNT_W;
  localparam int unsigned PW = (AW > POS_W) ? AW : POS_W;
  localparam int unsigned DW = (IW > POS_W) ? IW : POS_W;
  localparam logic [IW-1:0] DEPTH_V = IW'(BUFFER_DEPTH);

  logic [SLAVE_W-1:0] slave_q;
  logic               rmode_q;
  logic [COUNT_W-1:0] count_q;
  logic [IW-1:0]      idx_q, idx_d;
  done_e              outcome_q, outcome_d;

  logic [DW-1:0] pos_x;
  logic [PW-1:0] pos_w;
  logic          pos_ok;
  logic          idx_ok;
  logic [IW-1:0] idx_inc;
  logic [IW-1:0] idx_rx;

  assign pos_x   = DW'(pos_i);
  assign pos_w   = PW'(pos_i);
  assign pos_ok  = pos_x < DW'(BUFFER_DEPTH);
  assign idx_ok  = idx_q < DEPTH_V;
  assign idx_inc = idx_q + 1'b1;
  assign idx_rx  = idx_ok ? idx_inc : idx_q;

  always_comb begin
    res_o       = '0;
    mem_ctl_o   = '0;
    mem_addr_o  = pos_w[AW-1:0];
    mem_wdata_o = data_i;
    idx_d       = idx_q;
    outcome_d   = outcome_q;
    if (fire_i) begin
      unique case (req_i)
        REQ_LOAD: begin
          mem_ctl_o.en = pos_ok;
          mem_ctl_o.we = 1'b1;
        end
        REQ_READ: begin
          mem_ctl_o.en      = pos_ok;
          res_o.rd_from_mem = pos_ok;
        end
        REQ_START: begin
          idx_d           = '0;
          outcome_d       = DONE_BUSY;
          res_o.set_start = 1'b1;
        end
        REQ_STATUS: begin
          unique case (status_i)
            ST_BUS_ERROR: begin
              res_o.set_stop  = 1'b1;
              res_o.set_ack   = 1'b1;
              res_o.clear_irq = 1'b1;
            end
            ST_START, ST_RESTART: begin
              res_o.tx_valid    = 1'b1;
              res_o.tx_fixed    = {slave_q, rmode_q};
              res_o.clear_start = 1'b1;
              res_o.set_ack     = 1'b1;
              res_o.clear_irq   = 1'b1;
            end
            ST_SLA_W_ACK, ST_DATA_W_ACK: begin
              // first data byte goes out whatever the count
              if (status_i == ST_SLA_W_ACK || CW'(idx_q) < CW'(count_q)) begin
                res_o.tx_valid    = 1'b1;
                res_o.tx_from_mem = idx_ok;
                mem_ctl_o.en      = idx_ok;
                mem_addr_o        = idx_q[AW-1:0];
                idx_d             = idx_rx;
              end else begin
                res_o.set_stop = 1'b1;
                outcome_d      = DONE_WRITE_OK;
              end
              res_o.set_ack   = 1'b1;
              res_o.clear_irq = 1'b1;
            end
            ST_SLA_W_NACK: begin
              res_o.set_stop  = 1'b1;
              res_o.set_ack   = 1'b1;
              res_o.clear_irq = 1'b1;
              outcome_d       = DONE_ADDR_W_NACK;
            end
            ST_DATA_W_NACK: begin
              res_o.set_stop  = 1'b1;
              res_o.set_ack   = 1'b1;
              res_o.clear_irq = 1'b1;
              outcome_d       = DONE_DATA_NACK;
            end
            ST_ARB_LOST: begin
              res_o.set_start = 1'b1;
              res_o.set_ack   = 1'b1;
              res_o.clear_irq = 1'b1;
              outcome_d       = DONE_ARB_LOST;
            end
            ST_SLA_R_ACK: begin
              res_o.set_ack   = 1'b1;
              res_o.clear_irq = 1'b1;
            end
            ST_SLA_R_NACK: begin
              res_o.set_stop  = 1'b1;
              res_o.set_ack   = 1'b1;
              res_o.clear_irq = 1'b1;
              outcome_d       = DONE_ADDR_R_NACK;
            end
            ST_DATA_R_ACK: begin
              mem_ctl_o.en = idx_ok;
              mem_ctl_o.we = 1'b1;
              mem_addr_o   = idx_q[AW-1:0];
              idx_d        = idx_rx;
              // nack the last byte
              if (CW'(idx_rx) >= CW'(count_q)) begin
                res_o.clear_ack = 1'b1;
              end else begin
                res_o.set_ack = 1'b1;
              end
              res_o.clear_irq = 1'b1;
            end
            ST_DATA_R_NACK: begin
              mem_ctl_o.en    = idx_ok;
              mem_ctl_o.we    = 1'b1;
              mem_addr_o      = idx_q[AW-1:0];
              idx_d           = idx_rx;
              res_o.set_stop  = 1'b1;
              res_o.set_ack   = 1'b1;
              res_o.clear_irq = 1'b1;
              outcome_d       = DONE_READ_OK;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
    res_o.done_code = outcome_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      outcome_q <= DONE_BUSY;
    end else begin
      idx_q     <= idx_d;
      outcome_q <= outcome_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_q <= '0;
      rmode_q <= 1'b0;
      count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SLAVE_ADDR: slave_q <= cfg_data_i[SLAVE_W-1:0];
        CFG_READ_MODE:  rmode_q <= cfg_data_i[0];
        CFG_BYTE_COUNT: count_q <= cfg_data_i[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/i2c_master_status_handler.sv -----
// I2C master status handler: top level with stream ports and result register.
// Results are registered: an accepted input shows on the master side the next cycle.
// Throughput: one item per cycle unless the master stalls; each item makes at most one
// byte buffer RAM access, whose registered read data lands with the result register.
// Reset (async, active low) clears byte index, outcome, configuration and the
// result valid flag; the byte buffer is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2c_master_status_handler #(
  parameter int unsigned BUFFER_DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Slave side. tdata: buf_index[3:0], data_byte[11:4], bus_status[19:12], zero[23:20]
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [i2cms_pkg::S_TDATA_W-1:0]       s_axis_tdata,
  // tuser: req_type[1:0]
  input  logic [i2cms_pkg::S_TUSER_W-1:0]       s_axis_tuser,
  // Master side. tdata: tx_valid[0], tx_byte[8:1], set_start[9], clear_start[10],
  // set_stop[11], set_ack[12], clear_ack[13], clear_irq[14], done_code[17:15],
  // read_byte[25:18], zero[31:26]
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [i2cms_pkg::M_TDATA_W-1:0]       m_axis_tdata,
  // Configuration write port
  input  logic                                  cfg_we_i,
  input  logic [i2cms_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [i2cms_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import i2cms_pkg::*;

  localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  logic          in_fire;
  req_e          req;
  mem_ctl_t      mem_ctl;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;
  res_t          res_d, res_q;
  logic          m_valid_q;
  logic [7:0]    tx_byte;
  logic [7:0]    read_byte;

  // Result register frees up when it is empty or being drained this cycle.
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign req           = req_e'(s_axis_tuser);

  i2cms_seq #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .AW           (AW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (in_fire),
    .req_i       (req),
    .pos_i       (s_axis_tdata[3:0]),
    .data_i      (s_axis_tdata[11:4]),
    .status_i    (s_axis_tdata[19:12]),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .mem_ctl_o   (mem_ctl),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .res_o       (res_d)
  );

  // RAM read data is registered on the same edge as res_q, so the two line up.
  i2cms_buf_ram #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_buf (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      m_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  // Past the buffer end the fixed byte (zero) goes out instead of RAM data.
  assign tx_byte   = res_q.tx_from_mem ? mem_rdata : res_q.tx_fixed;
  assign read_byte = res_q.rd_from_mem ? mem_rdata : 8'h00;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'b0, read_byte, res_q.done_code, res_q.clear_irq,
                          res_q.clear_ack, res_q.set_ack, res_q.set_stop,
                          res_q.clear_start, res_q.set_start, tx_byte,
                          res_q.tx_valid};

  // Every accepted transfer shows up as a result in the next cycle.
  `ASSERT_NEXT(a_fire_result, clk_i, rst_ni, in_fire, m_axis_tvalid, "accepted item lost")
  // A start request restarts the outcome at busy and asks for a start condition.
  `ASSERT_NEXT(a_start_clears, clk_i, rst_ni, in_fire && req == REQ_START, m_axis_tvalid && res_q.set_start && res_q.done_code == DONE_BUSY, "start request mishandled")
  // One RAM read per item: never both a transmit byte and a read byte from it.
  `ASSERT_IMPL(a_one_rd_user, clk_i, rst_ni, m_axis_tvalid, !(res_q.tx_from_mem && res_q.rd_from_mem), "RAM data claimed twice")
  // A held result blocks new input so RAM read data is not overwritten.
  `ASSERT_IMPL(a_stall_blocks, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken while result stalled")

endmodule
